### src/mfap_pkg.sv
// ----------------------------------------------------------------------------
// mfap_pkg
// shared types, operation codes and constants of the max-flow block
// ----------------------------------------------------------------------------
package mfap_pkg;

  localparam int NODE_PORT_BITS = 4;
  localparam int CAP_PORT_BITS  = 32;
  localparam int FLOW_BITS      = 40;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_RUN   = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_SAME_NODE = 1'b1;

  typedef logic [3:0] op_t;

  localparam op_t OP_IDLE      = 4'd0;
  localparam op_t OP_CLEAR     = 4'd1;
  localparam op_t OP_COPY      = 4'd2;
  localparam op_t OP_COPY_TAIL = 4'd3;
  localparam op_t OP_BFS_INIT  = 4'd4;
  localparam op_t OP_POP       = 4'd5;
  localparam op_t OP_SCAN_RD   = 4'd6;
  localparam op_t OP_SCAN_CHK  = 4'd7;
  localparam op_t OP_NECK_RD   = 4'd8;
  localparam op_t OP_NECK_CHK  = 4'd9;
  localparam op_t OP_UPD_RD    = 4'd10;
  localparam op_t OP_UPD_WR1   = 4'd11;
  localparam op_t OP_UPD_WR2   = 4'd12;
  localparam op_t OP_FLOW_ADD  = 4'd13;
  localparam op_t OP_DONE      = 4'd14;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } ctrl_cmd_t;

  typedef struct packed {
    logic run_go;
    logic run_trivial;
    logic k_last;
    logic head_lt_tail;
    logic dst_visited;
    logic v_last;
    logic path_end;
    logic out_free;
  } dp_status_t;

endpackage

### src/mfap_ctrl.sv
// ----------------------------------------------------------------------------
// mfap_ctrl
// sequencer: clearing pass, matrix copy, search, bottleneck and update walks
// ----------------------------------------------------------------------------
module mfap_ctrl
  import mfap_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CLEAR     = 4'd1;
  localparam logic [3:0] S_COPY      = 4'd2;
  localparam logic [3:0] S_COPY_TAIL = 4'd3;
  localparam logic [3:0] S_BFS_INIT  = 4'd4;
  localparam logic [3:0] S_POP       = 4'd5;
  localparam logic [3:0] S_SCAN_RD   = 4'd6;
  localparam logic [3:0] S_SCAN_CHK  = 4'd7;
  localparam logic [3:0] S_NECK_RD   = 4'd8;
  localparam logic [3:0] S_NECK_CHK  = 4'd9;
  localparam logic [3:0] S_UPD_RD    = 4'd10;
  localparam logic [3:0] S_UPD_WR1   = 4'd11;
  localparam logic [3:0] S_UPD_WR2   = 4'd12;
  localparam logic [3:0] S_FLOW_ADD  = 4'd13;
  localparam logic [3:0] S_DONE      = 4'd14;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:     if (st.k_last) state_nxt = S_IDLE;
      S_IDLE:      if (st.run_go) state_nxt = st.run_trivial ? S_DONE : S_COPY;
      S_COPY:      if (st.k_last) state_nxt = S_COPY_TAIL;
      S_COPY_TAIL: state_nxt = S_BFS_INIT;
      S_BFS_INIT:  state_nxt = S_POP;
      S_POP: begin
        if (st.head_lt_tail)     state_nxt = S_SCAN_RD;
        else if (st.dst_visited) state_nxt = S_NECK_RD;
        else                     state_nxt = S_DONE;
      end
      S_SCAN_RD:   state_nxt = S_SCAN_CHK;
      S_SCAN_CHK:  state_nxt = st.v_last ? S_POP : S_SCAN_RD;
      S_NECK_RD:   state_nxt = st.path_end ? S_UPD_RD : S_NECK_CHK;
      S_NECK_CHK:  state_nxt = S_NECK_RD;
      S_UPD_RD:    state_nxt = st.path_end ? S_FLOW_ADD : S_UPD_WR1;
      S_UPD_WR1:   state_nxt = S_UPD_WR2;
      S_UPD_WR2:   state_nxt = S_UPD_RD;
      S_FLOW_ADD:  state_nxt = S_BFS_INIT;
      S_DONE:      if (st.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.in_ready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE:      cmd.op = OP_IDLE;
      S_CLEAR:     cmd.op = OP_CLEAR;
      S_COPY:      cmd.op = OP_COPY;
      S_COPY_TAIL: cmd.op = OP_COPY_TAIL;
      S_BFS_INIT:  cmd.op = OP_BFS_INIT;
      S_POP:       cmd.op = OP_POP;
      S_SCAN_RD:   cmd.op = OP_SCAN_RD;
      S_SCAN_CHK:  cmd.op = OP_SCAN_CHK;
      S_NECK_RD:   cmd.op = OP_NECK_RD;
      S_NECK_CHK:  cmd.op = OP_NECK_CHK;
      S_UPD_RD:    cmd.op = OP_UPD_RD;
      S_UPD_WR1:   cmd.op = OP_UPD_WR1;
      S_UPD_WR2:   cmd.op = OP_UPD_WR2;
      S_FLOW_ADD:  cmd.op = OP_FLOW_ADD;
      S_DONE:      cmd.op = OP_DONE;
      default:     cmd.op = OP_IDLE;
    endcase
  end

endmodule

### src/mfap_dpath.sv
// ----------------------------------------------------------------------------
// mfap_dpath
// capacity and residual memories, search queue, path walk and flow sum
// ----------------------------------------------------------------------------
module mfap_dpath
  import mfap_pkg::*;
#(
  parameter int NUM_NODES = 16,
  parameter int CAP_BITS  = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctrl_cmd_t                  cmd,
  output dp_status_t                 st,
  input  logic                       in_valid,
  input  logic                       in_command,
  input  logic [NODE_PORT_BITS-1:0]  in_from_node,
  input  logic [NODE_PORT_BITS-1:0]  in_to_node,
  input  logic [CAP_PORT_BITS-1:0]   in_capacity,
  input  logic [NODE_PORT_BITS-1:0]  in_source_node,
  input  logic [NODE_PORT_BITS-1:0]  in_sink_node,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [FLOW_BITS-1:0]       out_total_flow,
  output logic                       out_status
);

  localparam int NW    = $clog2(NUM_NODES);
  localparam int QW    = $clog2(NUM_NODES + 1);
  localparam int CELLS = NUM_NODES * NUM_NODES;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = CAP_BITS + 1;
  localparam int SW    = ((RW > FLOW_BITS) ? RW : FLOW_BITS) + 1;
  localparam logic [FLOW_BITS-1:0] FLOW_MAX = '1;

  function automatic logic [AW-1:0] cell_addr(logic [NW-1:0] r, logic [NW-1:0] c);
    return AW'(int'(r) * NUM_NODES + int'(c));
  endfunction

  logic [CAP_BITS-1:0] cap_mem [CELLS];
  logic [RW-1:0]       res_mem [CELLS];
  logic [CAP_BITS-1:0] cap_rdata_r;
  logic [RW-1:0]       res_rdata_r;

  logic [NUM_NODES-1:0] visited_r;
  logic [NW-1:0]        parent_r [NUM_NODES];
  logic [NW-1:0]        queue_r  [NUM_NODES];
  logic [QW-1:0]        head_r, tail_r, steps_r;
  logic [NW-1:0]        src_r, dst_r, u_r, v_r, pu_r;
  logic [RW-1:0]        neck_r;
  logic [FLOW_BITS-1:0] flow_r;
  logic                 status_r;
  logic [AW-1:0]        k_r, k_d_r;
  logic                 cp_wr_r;
  logic                 out_valid_r;
  logic [FLOW_BITS-1:0] out_flow_r;
  logic                 out_status_r;

  logic                 in_fire;
  logic                 from_ok, to_ok, src_ok, dst_ok;
  logic [NW-1:0]        par_v;
  logic [AW-1:0]        res_raddr, res_waddr;
  logic [RW-1:0]        res_wdata;
  logic                 res_we, res_re;
  logic [SW-1:0]        flow_sum;
  logic                 out_free;

  assign in_fire = in_valid && cmd.in_ready;
  assign from_ok = 32'(in_from_node)   < 32'(NUM_NODES);
  assign to_ok   = 32'(in_to_node)     < 32'(NUM_NODES);
  assign src_ok  = 32'(in_source_node) < 32'(NUM_NODES);
  assign dst_ok  = 32'(in_sink_node)   < 32'(NUM_NODES);
  assign par_v   = parent_r[v_r];
  assign out_free = !out_valid_r || out_ready;

  assign flow_sum = SW'(flow_r) + SW'(neck_r);

  // capacity store: clearing pass, writes, and copy reads
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLEAR) begin
      cap_mem[k_r] <= '0;
    end else if (in_fire && in_command == CMD_WRITE && from_ok && to_ok) begin
      cap_mem[cell_addr(NW'(in_from_node), NW'(in_to_node))] <= CAP_BITS'(in_capacity);
    end
    cap_rdata_r <= cap_mem[k_r];
  end

  // residual store ports
  always_comb begin
    res_re    = 1'b0;
    res_raddr = cell_addr(u_r, v_r);
    case (cmd.op)
      OP_SCAN_RD: res_re = 1'b1;
      OP_NECK_RD, OP_UPD_RD: begin
        res_re    = 1'b1;
        res_raddr = cell_addr(par_v, v_r);
      end
      OP_UPD_WR1: begin
        res_re    = 1'b1;
        res_raddr = cell_addr(v_r, pu_r);
      end
      default: res_re = 1'b0;
    endcase
  end

  always_comb begin
    res_we    = 1'b0;
    res_waddr = k_d_r;
    res_wdata = RW'(cap_rdata_r);
    if (cp_wr_r) begin
      res_we = 1'b1;
    end else if (cmd.op == OP_UPD_WR1) begin
      res_we    = 1'b1;
      res_waddr = cell_addr(pu_r, v_r);
      res_wdata = res_rdata_r - neck_r;
    end else if (cmd.op == OP_UPD_WR2) begin
      res_we    = 1'b1;
      res_waddr = cell_addr(v_r, pu_r);
      res_wdata = res_rdata_r + neck_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_waddr] <= res_wdata;
    if (res_re) res_rdata_r <= res_mem[res_raddr];
  end

  // search, walk and sum registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      cp_wr_r     <= 1'b0;
      visited_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      steps_r     <= '0;
      flow_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cp_wr_r <= (cmd.op == OP_COPY);
      // in done the result register is reloaded below instead
      if (out_valid_r && out_ready && cmd.op != OP_DONE) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_CLEAR: k_r <= st.k_last ? '0 : k_r + AW'(1);
        OP_IDLE: begin
          if (in_fire && in_command == CMD_RUN) begin
            src_r    <= NW'(in_source_node);
            dst_r    <= NW'(in_sink_node);
            k_r      <= '0;
            flow_r   <= '0;
            status_r <= (in_source_node == in_sink_node) ? STATUS_SAME_NODE : STATUS_OK;
          end
        end
        OP_COPY: begin
          k_d_r <= k_r;
          k_r   <= k_r + AW'(1);
        end
        OP_BFS_INIT: begin
          visited_r        <= NUM_NODES'(1) << src_r;
          parent_r[src_r]  <= src_r;
          queue_r[0]       <= src_r;
          head_r           <= '0;
          tail_r           <= QW'(1);
        end
        OP_POP: begin
          if (st.head_lt_tail) begin
            u_r    <= queue_r[head_r[NW-1:0]];
            head_r <= head_r + QW'(1);
            v_r    <= '0;
          end else begin
            v_r     <= dst_r;
            steps_r <= '0;
            neck_r  <= '1;
          end
        end
        OP_SCAN_CHK: begin
          if (!visited_r[v_r] && res_rdata_r != '0 && tail_r < QW'(NUM_NODES)) begin
            visited_r[v_r]            <= 1'b1;
            parent_r[v_r]             <= u_r;
            queue_r[tail_r[NW-1:0]]   <= v_r;
            tail_r                    <= tail_r + QW'(1);
          end
          if (!st.v_last) v_r <= v_r + NW'(1);
        end
        OP_NECK_RD, OP_UPD_RD: begin
          if (st.path_end) begin
            v_r     <= dst_r;
            steps_r <= '0;
          end else begin
            pu_r <= par_v;
          end
        end
        OP_NECK_CHK: begin
          if (res_rdata_r < neck_r) neck_r <= res_rdata_r;
          v_r     <= pu_r;
          steps_r <= steps_r + QW'(1);
        end
        OP_UPD_WR2: begin
          v_r     <= pu_r;
          steps_r <= steps_r + QW'(1);
        end
        OP_FLOW_ADD: begin
          flow_r <= (flow_sum > SW'(FLOW_MAX)) ? FLOW_MAX : FLOW_BITS'(flow_sum);
        end
        OP_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_flow_r   <= flow_r;
            out_status_r <= status_r;
          end
        end
        default: k_r <= k_r;
      endcase
    end
  end

  always_comb begin
    st.run_go       = in_fire && in_command == CMD_RUN;
    st.run_trivial  = (in_source_node == in_sink_node) || !src_ok || !dst_ok;
    st.k_last       = (k_r == AW'(CELLS - 1));
    st.head_lt_tail = (head_r < tail_r);
    st.dst_visited  = visited_r[dst_r];
    st.v_last       = (v_r == NW'(NUM_NODES - 1));
    st.path_end     = (v_r == src_r) || (steps_r == QW'(NUM_NODES));
    st.out_free     = out_free;
  end

  assign out_valid      = out_valid_r;
  assign out_total_flow = out_flow_r;
  assign out_status     = out_status_r;

  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= QW'(NUM_NODES))
    else $error("search queue tail beyond node count");

  a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("queue head passed tail");

  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && cmd.op != OP_DONE) |=> !out_valid_r)
    else $error("result beat repeated");

endmodule

### src/max_flow_augmenting_path_core.sv
// ----------------------------------------------------------------------------
// max_flow_augmenting_path_core
// edmonds-karp maximum flow over a dense capacity matrix
// ----------------------------------------------------------------------------
// operation: a write beat is stored while idle; a non-trivial run copies the
//   capacity matrix into the residual store, then per search scans neighbours
//   and walks the path for bottleneck and update, on one residual read port
// throughput: one write per cycle; one run at a time, next beat taken in idle
// reset: synchronous active low; a clearing pass zeroes all NUM_NODES^2
//   capacity cells (256 by default), in_ready is low meanwhile
// ----------------------------------------------------------------------------
module max_flow_augmenting_path_core
  import mfap_pkg::*;
#(
  parameter int NUM_NODES = 16,
  parameter int CAP_BITS  = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic [NODE_PORT_BITS-1:0] in_from_node,
  input  logic [NODE_PORT_BITS-1:0] in_to_node,
  input  logic [CAP_PORT_BITS-1:0]  in_capacity,
  input  logic [NODE_PORT_BITS-1:0] in_source_node,
  input  logic [NODE_PORT_BITS-1:0] in_sink_node,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [FLOW_BITS-1:0]      out_total_flow,
  output logic                      out_status
);

  // command from the sequencer, status back from the datapath
  ctrl_cmd_t  cmd;
  dp_status_t st;

  // beats are only taken while the sequencer sits in idle
  assign in_ready = cmd.in_ready;

  mfap_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  // memories, bfs queue, path walk and saturating flow sum
  mfap_dpath #(
    .NUM_NODES (NUM_NODES),
    .CAP_BITS  (CAP_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_valid       (in_valid),
    .in_command     (in_command),
    .in_from_node   (in_from_node),
    .in_to_node     (in_to_node),
    .in_capacity    (in_capacity),
    .in_source_node (in_source_node),
    .in_sink_node   (in_sink_node),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_total_flow (out_total_flow),
    .out_status     (out_status)
  );

endmodule

### bench/max_flow_augmenting_path_core_test.sv
// ----------------------------------------------------------------------------
// max_flow_augmenting_path_core_test
// self-checking bench: capacity writes and max-flow runs are sent over the
// input channel, an in-bench edmonds-karp predictor works out each run's
// total flow and status, and every result beat is compared in order
// ----------------------------------------------------------------------------
module max_flow_augmenting_path_core_test;
  import mfap_pkg::*;

  localparam int NODES = 16;
  localparam int CELLS = NODES * NODES;
  localparam logic [FLOW_BITS-1:0] FLOW_CEIL = {FLOW_BITS{1'b1}};

  typedef struct packed {
    logic [FLOW_BITS-1:0] total_flow;
    logic                 status;
  } flow_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = CMD_WRITE;
  logic [NODE_PORT_BITS-1:0] in_from_node = '0;
  logic [NODE_PORT_BITS-1:0] in_to_node = '0;
  logic [CAP_PORT_BITS-1:0] in_capacity = '0;
  logic [NODE_PORT_BITS-1:0] in_source_node = '0;
  logic [NODE_PORT_BITS-1:0] in_sink_node = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [FLOW_BITS-1:0] out_total_flow;
  logic out_status;

  // predictor copy of the capacity matrix
  logic [CAP_PORT_BITS-1:0] cap_matrix [CELLS];
  flow_result_t expected_flows [$];
  int mismatches = 0;
  int runs_sent = 0;
  int beats_sent = 0;

  max_flow_augmenting_path_core dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // edmonds-karp with ascending neighbour scan, exact integer arithmetic
  function automatic logic [FLOW_BITS-1:0] predict_flow(int src, int dst);
    logic [CAP_PORT_BITS:0] resid [CELLS];
    logic [NODES-1:0] seen;
    int parent [NODES];
    int fifo [NODES];
    int head, tail, u, v, steps;
    logic [CAP_PORT_BITS:0] neck;
    logic [FLOW_BITS-1:0] total;
    bit found;
    for (int i = 0; i < CELLS; i++) resid[i] = {1'b0, cap_matrix[i]};
    total = '0;
    found = 1'b1;
    while (found) begin
      head = 0;
      tail = 0;
      seen = '0;
      seen[src] = 1'b1;
      parent[src] = src;
      fifo[tail++] = src;
      while (head < tail) begin
        u = fifo[head++];
        for (v = 0; v < NODES; v++) begin
          if (!seen[v] && resid[u*NODES+v] != 0 && tail < NODES) begin
            seen[v] = 1'b1;
            parent[v] = u;
            fifo[tail++] = v;
          end
        end
      end
      found = seen[dst];
      if (found) begin
        neck = '1;
        v = dst;
        for (steps = 0; v != src && steps < NODES; steps++) begin
          u = parent[v];
          if (resid[u*NODES+v] < neck) neck = resid[u*NODES+v];
          v = u;
        end
        v = dst;
        for (steps = 0; v != src && steps < NODES; steps++) begin
          u = parent[v];
          resid[u*NODES+v] -= neck;
          resid[v*NODES+u] += neck;
          v = u;
        end
        // neck fits in 33 bits so it never reaches the ceiling alone
        if (total > FLOW_CEIL - FLOW_BITS'(neck)) total = FLOW_CEIL;
        else total = total + FLOW_BITS'(neck);
      end
    end
    return total;
  endfunction

  // one beat on the input channel; prediction is made at acceptance
  // valid is dropped only when an idle gap follows, or by drain
  task automatic send_beat(logic cmd, logic [3:0] from, logic [3:0] to,
                           logic [31:0] capv, logic [3:0] src, logic [3:0] dst);
    flow_result_t res;
    int gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_from_node <= from;
    in_to_node <= to;
    in_capacity <= capv;
    in_source_node <= src;
    in_sink_node <= dst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (cmd == CMD_WRITE) begin
      cap_matrix[from*NODES+to] = capv;
    end else begin
      runs_sent++;
      if (src == dst) begin
        res.total_flow = '0;
        res.status = STATUS_SAME_NODE;
      end else begin
        res.total_flow = predict_flow(src, dst);
        res.status = STATUS_OK;
      end
      expected_flows.push_back(res);
    end
  endtask

  task automatic write_edge(int from, int to, logic [31:0] capv);
    send_beat(CMD_WRITE, 4'(from), 4'(to), capv, 4'($urandom), 4'($urandom));
  endtask

  task automatic run_flow_cmd(int src, int dst);
    send_beat(CMD_RUN, 4'($urandom), 4'($urandom), $urandom, 4'(src), 4'(dst));
  endtask

  // wait for every outstanding run to report
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_flows.size() != 0) @(posedge clk);
  endtask

  task automatic clear_matrix;
    for (int i = 0; i < CELLS; i++)
      if (cap_matrix[i] != 0) write_edge(i / NODES, i % NODES, 32'd0);
  endtask

  // result side: random stall per beat, checks against oldest expectation
  initial begin
    flow_result_t want;
    int stall;
    forever begin
      stall = $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_flows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat flow=%h status=%b",
                                       out_total_flow, out_status);
      end else begin
        want = expected_flows.pop_front();
        if (out_total_flow !== want.total_flow || out_status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected flow=%h status=%b, got flow=%h status=%b",
                     want.total_flow, want.status, out_total_flow, out_status);
        end
      end
    end
  end

  // empty matrix, same node, extremes of every field
  task automatic test_directed;
    run_flow_cmd(0, 15);
    run_flow_cmd(7, 7);
    run_flow_cmd(15, 15);
    write_edge(0, 15, 32'hFFFF_FFFF);
    write_edge(15, 0, 32'h0000_0001);
    run_flow_cmd(0, 15);
    run_flow_cmd(15, 0);
    // two parallel saturated paths push the sum past 32 bits
    write_edge(0, 1, 32'hFFFF_FFFF);
    write_edge(1, 15, 32'hFFFF_FFFF);
    write_edge(0, 2, 32'hAAAA_5555);
    write_edge(2, 15, 32'h5555_AAAA);
    run_flow_cmd(0, 15);
    // overwrite an entry, then remove an edge with zero
    write_edge(0, 15, 32'h0001_0000);
    write_edge(0, 2, 32'd0);
    run_flow_cmd(0, 15);
    run_flow_cmd(1, 0);
    drain();
    clear_matrix();
    drain();
  endtask

  // full matrix of large capacities: many paths, wide sums
  task automatic test_dense_graph;
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++)
        if (i != j) write_edge(i, j, $urandom | 32'h8000_0000);
    run_flow_cmd(0, 15);
    run_flow_cmd(15, 0);
    run_flow_cmd(3, 9);
    drain();
    clear_matrix();
    drain();
  endtask

  // random graphs: mostly sparse writes followed by runs
  task automatic test_random_graphs;
    logic [31:0] capv;
    while (beats_sent < 1250) begin
      if ($urandom_range(0, 9) == 0) begin
        clear_matrix();
        drain();
      end
      repeat ($urandom_range(4, 30)) begin
        case ($urandom_range(0, 3))
          0: capv = $urandom;
          1: capv = $urandom_range(1, 16) << 16;
          2: capv = 32'd0;
          default: capv = $urandom_range(1, 255);
        endcase
        write_edge($urandom_range(0, 15), $urandom_range(0, 15), capv);
      end
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 9) == 0) run_flow_cmd(5, 5);
        else run_flow_cmd($urandom_range(0, 15), $urandom_range(0, 15));
      end
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) cap_matrix[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_dense_graph();
    test_random_graphs();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_flows.size() == 0) begin
      $display("max_flow_augmenting_path_core verification clean");
    end else begin
      $display("max_flow_augmenting_path_core verification failed");
    end
    $finish;
  end

  // timeout that leaves room for slow runs on dense graphs
  initial begin
    #400000000;
    $display("max_flow_augmenting_path_core verification failed");
    $finish;
  end

endmodule
